[hw/rtl/lca_pkg.sv]
// Shared types and codes for the torus life block.
`timescale 1ns / 1ps
package lca_pkg;

    // Vertical window of one column: the rows above, at and below the row in work.
    typedef struct packed {
        logic n;
        logic c;
        logic s;
    } t_win;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    localparam logic [1:0] CFG_ROWS = 2'd0;
    localparam logic [1:0] CFG_COLS = 2'd1;
    localparam logic [1:0] CFG_GENS = 2'd2;

endpackage

[hw/rtl/life_cellular_automaton_torus_unit.sv]
// Top level of the Game of Life (B3/S23) torus block: command decode, sequencer, board.
`timescale 1ns / 1ps
// The block keeps a MAX_ROWS x MAX_COLS one-bit board, wrapped on both edges at the
// configured rows_in_use / cols_in_use (each clamped into 3..MAX). Raise start for one
// request while busy is low; every request gives exactly one result, shown for a single
// cycle with o_done high, and the receiver cannot stall it. A write, a no-op, and a read
// outside the board in use answer in the next cycle; a read inside it answers after the
// registered memory read, through S_RD_WAIT. In a run request each generation loads
// three rows into the cell chain, then handles each row in a memory read state and a
// row write-back state, since the board memory has one read and one write port. A run
// with zero generations answers in the next cycle. After reset the board is swept to
// all-dead, one row per cycle through all MAX_ROWS rows, with busy high; configuration
// writes are taken throughout.
// Configure only while no request is in flight.
module life_cellular_automaton_torus_unit
    import lca_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [5:0]  i_row,
    input  logic [5:0]  i_col,
    input  logic        i_cell_in,
    output logic        o_done,
    output logic        o_cell_out,
    output logic        o_run_finished,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    localparam int RAW = $clog2(MAX_ROWS);
    localparam int CAW = $clog2(MAX_COLS);
    localparam int RSW = $clog2(MAX_ROWS + 1);
    localparam int CSW = $clog2(MAX_COLS + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_WAIT,
        S_FILL_RD,
        S_FILL_SH,
        S_ROW_RD,
        S_ROW_WR
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [6:0]  r_rows_cfg;
    logic [6:0]  r_cols_cfg;
    logic [15:0] r_gens;

    // Sequencer.
    logic [RAW-1:0] r_cnt;
    logic [1:0]     r_fill;
    logic [15:0]    r_gen;

    // Result registers.
    logic r_done;
    logic r_cell_out;
    logic r_run_fin;

    // Payload held across cycles.
    logic [MAX_COLS-1:0] r_row0;
    logic [CAW-1:0]      r_col;

    logic [RSW-1:0]      w_nr;
    logic [CSW-1:0]      w_nc;
    logic                w_accept;
    logic                w_inside;
    logic                w_last_row;
    logic                w_s2_ok;
    logic [RAW-1:0]      w_fill_addr;

    logic [RAW-1:0]      w_waddr;
    logic [MAX_COLS-1:0] w_wmask;
    logic [MAX_COLS-1:0] w_wdata;
    logic                w_re;
    logic [RAW-1:0]      w_raddr;
    logic [MAX_COLS-1:0] w_rdata;

    logic                w_shift;
    logic [MAX_COLS-1:0] w_south;
    logic [MAX_COLS-1:0] w_next_row;

    // Clamp the configured board size into 3..MAX.
    always_comb begin
        if (r_rows_cfg < 7'd3) begin
            w_nr = RSW'(3);
        end else if (int'(r_rows_cfg) > MAX_ROWS) begin
            w_nr = RSW'(MAX_ROWS);
        end else begin
            w_nr = RSW'(r_rows_cfg);
        end
        if (r_cols_cfg < 7'd3) begin
            w_nc = CSW'(3);
        end else if (int'(r_cols_cfg) > MAX_COLS) begin
            w_nc = CSW'(MAX_COLS);
        end else begin
            w_nc = CSW'(r_cols_cfg);
        end
    end

    assign busy       = (r_state != S_IDLE);
    assign w_accept   = start && !busy;
    assign w_inside   = (int'(i_row) < int'(w_nr)) && (int'(i_col) < int'(w_nc));
    assign w_last_row = (int'(r_cnt) == int'(w_nr) - 1);
    // Row r+2 is still unwritten in memory; past the last row, wrap to the saved row 0.
    assign w_s2_ok    = (int'(r_cnt) + 2 < int'(w_nr));
    // Load order per generation: last row, row 0, row 1.
    assign w_fill_addr = (r_fill == 2'd0) ? RAW'(int'(w_nr) - 1) : RAW'(int'(r_fill) - 1);

    // Memory port control.
    always_comb begin
        w_waddr = '0;
        w_wmask = '0;
        w_wdata = '0;
        w_re    = 1'b0;
        w_raddr = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_waddr = r_cnt;
                w_wmask = '1;
            end
            S_IDLE: begin
                if (w_accept && w_inside && (t_cmd'(i_command) == CMD_WRITE)) begin
                    w_waddr               = RAW'(i_row);
                    w_wmask[CAW'(i_col)]  = 1'b1;
                    w_wdata               = {MAX_COLS{i_cell_in}};
                end
                if (w_accept && w_inside && (t_cmd'(i_command) == CMD_READ)) begin
                    w_re    = 1'b1;
                    w_raddr = RAW'(i_row);
                end
            end
            S_FILL_RD: begin
                w_re    = 1'b1;
                w_raddr = w_fill_addr;
            end
            S_ROW_RD: begin
                w_re    = w_s2_ok;
                w_raddr = RAW'(int'(r_cnt) + 2);
            end
            S_ROW_WR: begin
                w_waddr = r_cnt;
                w_wmask = '1;
                w_wdata = w_next_row;
            end
            default: begin
            end
        endcase
    end

    // Slide the cell windows one row down on every load and every row write-back.
    assign w_shift = (r_state == S_FILL_SH) || (r_state == S_ROW_WR);
    assign w_south = ((r_state == S_ROW_WR) && !w_s2_ok) ? r_row0 : w_rdata;

    lca_mem #(
        .DEPTH (MAX_ROWS),
        .WIDTH (MAX_COLS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_waddr (w_waddr),
        .i_wmask (w_wmask),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    lca_row #(
        .MAX_COLS (MAX_COLS)
    ) u_row (
        .i_clk   (i_clk),
        .i_shift (w_shift),
        .i_south (w_south),
        .i_ncols (w_nc),
        .o_next  (w_next_row)
    );

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= 7'd64;
            r_cols_cfg <= 7'd64;
            r_gens     <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROWS: r_rows_cfg <= i_cfg_data[6:0];
                CFG_COLS: r_cols_cfg <= i_cfg_data[6:0];
                CFG_GENS: r_gens     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Hold the original row 0 (south neighbor of the last row) and the read column.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_FILL_SH) && (r_fill == 2'd1)) begin
            r_row0 <= w_rdata;
        end
        if (w_accept) begin
            r_col <= CAW'(i_col);
        end
    end

    // Sequencer and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_cnt      <= '0;
            r_fill     <= '0;
            r_gen      <= '0;
            r_done     <= 1'b0;
            r_cell_out <= 1'b0;
            r_run_fin  <= 1'b0;
        end else begin
            r_done     <= 1'b0;
            r_cell_out <= 1'b0;
            r_run_fin  <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    if (r_cnt == RAW'(MAX_ROWS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + RAW'(1);
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        unique case (t_cmd'(i_command)) inside
                            CMD_READ: begin
                                if (w_inside) begin
                                    r_state <= S_RD_WAIT;
                                end else begin
                                    r_done <= 1'b1;
                                end
                            end
                            CMD_RUN: begin
                                if (r_gens == 16'd0) begin
                                    r_done    <= 1'b1;
                                    r_run_fin <= 1'b1;
                                end else begin
                                    r_gen   <= r_gens;
                                    r_cnt   <= '0;
                                    r_fill  <= '0;
                                    r_state <= S_FILL_RD;
                                end
                            end
                            CMD_WRITE, CMD_NOP: begin
                                r_done <= 1'b1;
                            end
                            default: begin
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                S_RD_WAIT: begin
                    r_done     <= 1'b1;
                    r_cell_out <= w_rdata[r_col];
                    r_state    <= S_IDLE;
                end
                S_FILL_RD: begin
                    r_state <= S_FILL_SH;
                end
                S_FILL_SH: begin
                    if (r_fill == 2'd2) begin
                        r_fill  <= '0;
                        r_state <= S_ROW_RD;
                    end else begin
                        r_fill  <= r_fill + 2'd1;
                        r_state <= S_FILL_RD;
                    end
                end
                S_ROW_RD: begin
                    r_state <= S_ROW_WR;
                end
                S_ROW_WR: begin
                    if (w_last_row) begin
                        r_cnt <= '0;
                        if (r_gen == 16'd1) begin
                            r_done    <= 1'b1;
                            r_run_fin <= 1'b1;
                            r_state   <= S_IDLE;
                        end else begin
                            r_gen   <= r_gen - 16'd1;
                            r_state <= S_FILL_RD;
                        end
                    end else begin
                        r_cnt   <= r_cnt + RAW'(1);
                        r_state <= S_ROW_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done         = r_done;
    assign o_cell_out     = r_cell_out;
    assign o_run_finished = r_run_fin;

    // A result never carries both a cell value and a run report.
    a_exclusive_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_cell_out && o_run_finished))
        else $error("result carries both a cell value and a run report");

    // Write and no-op requests answer in the next cycle with empty fields.
    a_write_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && ((t_cmd'(i_command) == CMD_WRITE) || (t_cmd'(i_command) == CMD_NOP)))
        |=> (o_done && !o_cell_out && !o_run_finished))
        else $error("write or no-op request not answered in the next cycle");

    // A run of zero generations reports completion at once.
    a_zero_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (t_cmd'(i_command) == CMD_RUN) && (r_gens == 16'd0))
        |=> (o_done && o_run_finished))
        else $error("zero-generation run not reported at once");

    // No result appears while a generation is still sweeping rows.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ROW_WR) && !w_last_row) |=> !o_done)
        else $error("result shown in the middle of a generation");

endmodule

[hw/rtl/lca_mem.sv]
// Board memory: one row per word, bit-enable write port, registered read port.
`timescale 1ns / 1ps
module lca_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wmask,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < WIDTH; b++) begin
            if (i_wmask[b]) begin
                r_mem[i_waddr][b] <= i_wdata[b];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/lca_cell.sv]
// One column cell: holds its three-row window and computes the B3/S23 next state.
`timescale 1ns / 1ps
module lca_cell
    import lca_pkg::*;
(
    input  logic i_clk,
    input  logic i_shift,
    input  logic i_south,
    input  logic i_active,
    input  t_win i_west,
    input  t_win i_east,
    output t_win o_win,
    output logic o_next
);

    t_win       r_win;
    logic [3:0] w_count;

    // Advance the window one row down the board.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_win.n <= r_win.c;
            r_win.c <= r_win.s;
            r_win.s <= i_south;
        end
    end

    always_comb begin
        w_count = 4'(r_win.n) + 4'(r_win.s)
                + 4'(i_west.n) + 4'(i_west.c) + 4'(i_west.s)
                + 4'(i_east.n) + 4'(i_east.c) + 4'(i_east.s);
    end

    // Columns beyond the board in use hold their value.
    assign o_next = i_active ? ((w_count == 4'd3) || ((w_count == 4'd2) && r_win.c))
                             : r_win.c;
    assign o_win  = r_win;

endmodule

[hw/rtl/lca_row.sv]
// Chain of column cells with toroidal wrap between the first and last column in use.
`timescale 1ns / 1ps
module lca_row
    import lca_pkg::*;
#(
    parameter int MAX_COLS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_shift,
    input  logic [MAX_COLS-1:0]          i_south,
    input  logic [$clog2(MAX_COLS+1)-1:0] i_ncols,
    output logic [MAX_COLS-1:0]          o_next
);

    localparam int CAW = $clog2(MAX_COLS);
    localparam int CSW = $clog2(MAX_COLS + 1);

    t_win w_win [MAX_COLS];
    t_win w_wrap_west;

    assign w_wrap_west = w_win[CAW'(i_ncols - CSW'(1))];

    for (genvar c = 0; c < MAX_COLS; c++) begin : g_cell
        localparam int EI = (c + 1) % MAX_COLS;
        t_win w_west;
        t_win w_east;

        if (c == 0) begin : g_first
            assign w_west = w_wrap_west;
        end else begin : g_rest
            assign w_west = w_win[c-1];
        end

        assign w_east = (i_ncols == CSW'(c + 1)) ? w_win[0] : w_win[EI];

        lca_cell u_cell (
            .i_clk    (i_clk),
            .i_shift  (i_shift),
            .i_south  (i_south[c]),
            .i_active (CSW'(c) < i_ncols),
            .i_west   (w_west),
            .i_east   (w_east),
            .o_win    (w_win[c]),
            .o_next   (o_next[c])
        );
    end

endmodule
